>>> src/tsaf_pkg.sv
// ----------------------------------------------------------------------------
// tsaf_pkg
// Types, phase codes and helpers shared by the adaptation field parser.
// ----------------------------------------------------------------------------
package tsaf_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_FLAGS    = 4'd1,
        PH_PCR      = 4'd2,
        PH_OPCR     = 4'd3,
        PH_SPLICE   = 4'd4,
        PH_PRIVLEN  = 4'd5,
        PH_PRIVSKIP = 4'd6,
        PH_EXTLEN   = 4'd7,
        PH_EXTFLAGS = 4'd8,
        PH_LTW      = 4'd9,
        PH_PIECE    = 4'd10,
        PH_SEAM     = 4'd11,
        PH_EXTSKIP  = 4'd12,
        PH_STUFF    = 4'd13
    } t_phase;

    localparam int unsigned NUM_ITEM_PHASES = 13;

    localparam logic [2:0] PCR_BYTES  = 3'd6;
    localparam logic [2:0] LTW_BYTES  = 3'd2;
    localparam logic [2:0] PIECE_BYTES = 3'd3;
    localparam logic [2:0] SEAM_BYTES = 3'd5;

    typedef struct packed {
        logic       valid;
        logic [7:0] field_byte;
        logic       first;
    } t_stage;

    typedef struct packed {
        logic [7:0]        header_flags;
        logic [32:0]       pcr_base;
        logic [8:0]        pcr_extension;
        logic [32:0]       opcr_base;
        logic [8:0]        opcr_extension;
        logic signed [7:0] splice_cntdn;
        logic [7:0]        private_length;
        logic [7:0]        extension_info;
        logic [14:0]       ltw_ofs;
        logic [21:0]       pw_rate;
        logic [32:0]       dts_next_au;
        logic              malformed;
    } t_record;

    function automatic logic [2:0] multi_len(t_phase p);
        logic [2:0] len;
        case (p)
            PH_LTW:   len = LTW_BYTES;
            PH_PIECE: len = PIECE_BYTES;
            PH_SEAM:  len = SEAM_BYTES;
            default:  len = PCR_BYTES;
        endcase
        return len;
    endfunction

    // first phase after p whose content is present, else stuffing
    function automatic t_phase next_phase(t_phase p, logic [NUM_ITEM_PHASES-1:0] pres);
        t_phase n;
        logic   hit;
        n   = PH_STUFF;
        hit = 1'b0;
        for (int k = 1; k < NUM_ITEM_PHASES; k++) begin
            if (!hit && (k > int'(p)) && pres[k]) begin
                n   = t_phase'(4'(k));
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

>>> src/tsaf_if.sv
// ----------------------------------------------------------------------------
// tsaf_byte_if / tsaf_rec_if
// Valid/ready channels for field bytes in and parsed records out.
// ----------------------------------------------------------------------------
interface tsaf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] field_byte;
    logic       first;

    modport source (output valid, output field_byte, output first, input ready);
    modport sink   (input valid, input field_byte, input first, output ready);
endinterface

interface tsaf_rec_if;
    logic              valid;
    logic              ready;
    logic [7:0]        header_flags;
    logic [32:0]       pcr_base;
    logic [8:0]        pcr_extension;
    logic [32:0]       opcr_base;
    logic [8:0]        opcr_extension;
    logic signed [7:0] splice_cntdn;
    logic [7:0]        private_length;
    logic [7:0]        extension_info;
    logic [14:0]       ltw_ofs;
    logic [21:0]       pw_rate;
    logic [32:0]       dts_next_au;
    logic              malformed;

    modport source (
        output valid, input ready,
        output header_flags, output pcr_base, output pcr_extension,
        output opcr_base, output opcr_extension, output splice_cntdn,
        output private_length, output extension_info, output ltw_ofs,
        output pw_rate, output dts_next_au, output malformed
    );
    modport sink (
        input valid, output ready,
        input header_flags, input pcr_base, input pcr_extension,
        input opcr_base, input opcr_extension, input splice_cntdn,
        input private_length, input extension_info, input ltw_ofs,
        input pw_rate, input dts_next_au, input malformed
    );
endinterface

>>> src/tsaf_in_reg.sv
// ----------------------------------------------------------------------------
// tsaf_in_reg
// Input register stage holding one field byte for the parser.
// ----------------------------------------------------------------------------
module tsaf_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tsaf_byte_if.sink            i_byte,
    input  logic                 i_adv,
    output tsaf_pkg::t_stage     o_stage
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_first;

    assign i_byte.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_byte  <= i_byte.field_byte;
            r_first <= i_byte.first;
        end
    end

    assign o_stage.valid      = r_valid;
    assign o_stage.field_byte = r_byte;
    assign o_stage.first      = r_first;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_adv |=> r_valid && $stable(r_byte) && $stable(r_first))
        else $error("stalled byte changed in input stage");

    a_adv_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |-> r_valid)
        else $error("parser advanced on empty input stage");

endmodule

>>> src/tsaf_parser.sv
// ----------------------------------------------------------------------------
// tsaf_parser
// Per-byte adaptation field state machine and record assembly.
// ----------------------------------------------------------------------------
module tsaf_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsaf_pkg::t_stage     i_stage,
    input  logic                 i_out_free,
    output logic                 o_fire,
    output logic                 o_emit,
    output tsaf_pkg::t_record    o_rec
);

    tsaf_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_field_length, n_field_length;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_skip_rem, n_skip_rem;
    logic [7:0]  r_ext_rem, n_ext_rem;
    logic [47:0] r_gather, n_gather;
    logic [7:0]  r_hdr, n_hdr;
    logic [32:0] r_pcr_base, n_pcr_base;
    logic [8:0]  r_pcr_ext, n_pcr_ext;
    logic [32:0] r_opcr_base, n_opcr_base;
    logic [8:0]  r_opcr_ext, n_opcr_ext;
    logic [7:0]  r_splice, n_splice;
    logic [7:0]  r_priv_len, n_priv_len;
    logic        r_malf, n_malf;
    logic [7:0]  r_ext_info, n_ext_info;
    logic [14:0] r_ltw, n_ltw;
    logic [21:0] r_piece, n_piece;
    logic [32:0] r_dts, n_dts;

    logic last_byte;

    assign last_byte = i_stage.first ? (i_stage.field_byte == 8'd0)
                     : ((r_phase != tsaf_pkg::PH_IDLE) &&
                        (8'(r_byte_count + 8'd1) == r_field_length));
    assign o_emit = i_stage.valid && last_byte;
    assign o_fire = i_stage.valid && (!last_byte || i_out_free);

    always_comb begin : p_next
        logic [tsaf_pkg::NUM_ITEM_PHASES-1:0] pres;
        logic                                 adv_ph;
        logic [7:0]                           b;
        b              = i_stage.field_byte;
        pres           = '0;
        adv_ph         = 1'b0;
        n_phase        = r_phase;
        n_field_length = r_field_length;
        n_byte_count   = r_byte_count;
        n_idx          = r_idx;
        n_skip_rem     = r_skip_rem;
        n_ext_rem      = r_ext_rem;
        n_gather       = r_gather;
        n_hdr          = r_hdr;
        n_pcr_base     = r_pcr_base;
        n_pcr_ext      = r_pcr_ext;
        n_opcr_base    = r_opcr_base;
        n_opcr_ext     = r_opcr_ext;
        n_splice       = r_splice;
        n_priv_len     = r_priv_len;
        n_malf         = r_malf;
        n_ext_info     = r_ext_info;
        n_ltw          = r_ltw;
        n_piece        = r_piece;
        n_dts          = r_dts;

        if (i_stage.first) begin
            n_field_length = b;
            n_byte_count   = '0;
            n_idx          = '0;
            n_skip_rem     = '0;
            n_ext_rem      = '0;
            n_gather       = '0;
            n_hdr          = '0;
            n_pcr_base     = '0;
            n_pcr_ext      = '0;
            n_opcr_base    = '0;
            n_opcr_ext     = '0;
            n_splice       = '0;
            n_priv_len     = '0;
            n_malf         = 1'b0;
            n_ext_info     = '0;
            n_ltw          = '0;
            n_piece        = '0;
            n_dts          = '0;
            n_phase        = (b == 8'd0) ? tsaf_pkg::PH_IDLE : tsaf_pkg::PH_FLAGS;
        end else if (r_phase != tsaf_pkg::PH_IDLE) begin
            n_byte_count = 8'(r_byte_count + 8'd1);
            case (r_phase)
                tsaf_pkg::PH_FLAGS: begin
                    n_hdr  = b;
                    adv_ph = 1'b1;
                end
                tsaf_pkg::PH_PCR, tsaf_pkg::PH_OPCR, tsaf_pkg::PH_LTW,
                tsaf_pkg::PH_PIECE, tsaf_pkg::PH_SEAM: begin
                    if (r_phase inside {tsaf_pkg::PH_LTW, tsaf_pkg::PH_PIECE,
                                        tsaf_pkg::PH_SEAM}) begin
                        if (r_ext_rem == 8'd0) begin
                            n_malf = 1'b1;
                        end else begin
                            n_ext_rem = 8'(r_ext_rem - 8'd1);
                        end
                    end
                    n_gather = {r_gather[39:0], b};
                    n_idx    = 3'(r_idx + 3'd1);
                    if (n_idx == tsaf_pkg::multi_len(r_phase)) begin
                        adv_ph = 1'b1;
                        case (r_phase)
                            tsaf_pkg::PH_PCR: begin
                                n_pcr_base = n_gather[47:15];
                                n_pcr_ext  = n_gather[8:0];
                            end
                            tsaf_pkg::PH_OPCR: begin
                                n_opcr_base = n_gather[47:15];
                                n_opcr_ext  = n_gather[8:0];
                            end
                            tsaf_pkg::PH_LTW: begin
                                n_ext_info[3] = r_ext_info[3] | n_gather[15];
                                n_ltw         = r_ltw | n_gather[14:0];
                            end
                            tsaf_pkg::PH_PIECE: begin
                                n_piece = r_piece | n_gather[21:0];
                            end
                            default: begin
                                n_ext_info[7:4] = r_ext_info[7:4] | n_gather[39:36];
                                n_dts = {n_gather[35:33], n_gather[31:17], n_gather[15:1]};
                            end
                        endcase
                    end
                end
                tsaf_pkg::PH_SPLICE: begin
                    n_splice = r_splice | b;
                    adv_ph   = 1'b1;
                end
                tsaf_pkg::PH_PRIVLEN: begin
                    n_priv_len = r_priv_len | b;
                    n_skip_rem = b;
                    adv_ph     = 1'b1;
                end
                tsaf_pkg::PH_PRIVSKIP: begin
                    if (r_skip_rem != 8'd0) begin
                        n_skip_rem = 8'(r_skip_rem - 8'd1);
                    end
                    adv_ph = (n_skip_rem == 8'd0);
                end
                tsaf_pkg::PH_EXTLEN: begin
                    n_ext_rem = b;
                    adv_ph    = 1'b1;
                end
                tsaf_pkg::PH_EXTFLAGS: begin
                    if (r_ext_rem == 8'd0) begin
                        n_malf = 1'b1;
                    end else begin
                        n_ext_rem = 8'(r_ext_rem - 8'd1);
                    end
                    n_ext_info[2:0] = r_ext_info[2:0] | {b[5], b[6], b[7]};
                    adv_ph          = 1'b1;
                end
                tsaf_pkg::PH_EXTSKIP: begin
                    if (r_ext_rem != 8'd0) begin
                        n_ext_rem = 8'(r_ext_rem - 8'd1);
                    end
                    adv_ph = (n_ext_rem == 8'd0);
                end
                default: begin
                    adv_ph = 1'b0;
                end
            endcase

            pres[tsaf_pkg::PH_PCR]      = n_hdr[4];
            pres[tsaf_pkg::PH_OPCR]     = n_hdr[3];
            pres[tsaf_pkg::PH_SPLICE]   = n_hdr[2];
            pres[tsaf_pkg::PH_PRIVLEN]  = n_hdr[1];
            pres[tsaf_pkg::PH_PRIVSKIP] = (n_skip_rem != 8'd0);
            pres[tsaf_pkg::PH_EXTLEN]   = n_hdr[0];
            pres[tsaf_pkg::PH_EXTFLAGS] = (n_ext_rem != 8'd0);
            pres[tsaf_pkg::PH_LTW]      = n_ext_info[0];
            pres[tsaf_pkg::PH_PIECE]    = n_ext_info[1];
            pres[tsaf_pkg::PH_SEAM]     = n_ext_info[2];
            pres[tsaf_pkg::PH_EXTSKIP]  = (n_ext_rem != 8'd0);

            if (adv_ph) begin
                n_phase  = tsaf_pkg::next_phase(r_phase, pres);
                n_idx    = '0;
                n_gather = '0;
            end
        end

        o_rec.header_flags   = n_hdr;
        o_rec.pcr_base       = n_pcr_base;
        o_rec.pcr_extension  = n_pcr_ext;
        o_rec.opcr_base      = n_opcr_base;
        o_rec.opcr_extension = n_opcr_ext;
        o_rec.splice_cntdn   = n_splice;
        o_rec.private_length = n_priv_len;
        o_rec.extension_info = n_ext_info;
        o_rec.ltw_ofs        = n_ltw;
        o_rec.pw_rate        = n_piece;
        o_rec.dts_next_au    = n_dts;
        o_rec.malformed      = !i_stage.first &&
                               (n_malf || (n_phase != tsaf_pkg::PH_STUFF));

        if (last_byte) begin
            n_phase = tsaf_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= tsaf_pkg::PH_IDLE;
            r_field_length <= '0;
            r_byte_count   <= '0;
            r_idx          <= '0;
            r_skip_rem     <= '0;
            r_ext_rem      <= '0;
            r_gather       <= '0;
            r_hdr          <= '0;
            r_pcr_base     <= '0;
            r_pcr_ext      <= '0;
            r_opcr_base    <= '0;
            r_opcr_ext     <= '0;
            r_splice       <= '0;
            r_priv_len     <= '0;
            r_malf         <= 1'b0;
            r_ext_info     <= '0;
            r_ltw          <= '0;
            r_piece        <= '0;
            r_dts          <= '0;
        end else if (o_fire) begin
            r_phase        <= n_phase;
            r_field_length <= n_field_length;
            r_byte_count   <= n_byte_count;
            r_idx          <= n_idx;
            r_skip_rem     <= n_skip_rem;
            r_ext_rem      <= n_ext_rem;
            r_gather       <= n_gather;
            r_hdr          <= n_hdr;
            r_pcr_base     <= n_pcr_base;
            r_pcr_ext      <= n_pcr_ext;
            r_opcr_base    <= n_opcr_base;
            r_opcr_ext     <= n_opcr_ext;
            r_splice       <= n_splice;
            r_priv_len     <= n_priv_len;
            r_malf         <= n_malf;
            r_ext_info     <= n_ext_info;
            r_ltw          <= n_ltw;
            r_piece        <= n_piece;
            r_dts          <= n_dts;
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != tsaf_pkg::PH_IDLE |-> r_byte_count < r_field_length)
        else $error("byte count reached field length while parsing");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < tsaf_pkg::PCR_BYTES)
        else $error("multi-byte index out of range");

    a_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stage.valid && i_stage.first && (i_stage.field_byte == 8'd0)
        |-> o_emit && (o_rec == '0))
        else $error("zero length field did not give an empty record");

    a_emit_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire && o_emit |=> r_phase == tsaf_pkg::PH_IDLE)
        else $error("parser not idle after record");

endmodule

>>> src/tsaf_out_reg.sv
// ----------------------------------------------------------------------------
// tsaf_out_reg
// Result register that holds one record until it is taken.
// ----------------------------------------------------------------------------
module tsaf_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  tsaf_pkg::t_record    i_rec,
    output logic                 o_free,
    tsaf_rec_if.source           o_rec
);

    logic              r_valid;
    tsaf_pkg::t_record r_rec;

    assign o_free = !r_valid || o_rec.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rec.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec.valid          = r_valid;
    assign o_rec.header_flags   = r_rec.header_flags;
    assign o_rec.pcr_base       = r_rec.pcr_base;
    assign o_rec.pcr_extension  = r_rec.pcr_extension;
    assign o_rec.opcr_base      = r_rec.opcr_base;
    assign o_rec.opcr_extension = r_rec.opcr_extension;
    assign o_rec.splice_cntdn   = r_rec.splice_cntdn;
    assign o_rec.private_length = r_rec.private_length;
    assign o_rec.extension_info = r_rec.extension_info;
    assign o_rec.ltw_ofs        = r_rec.ltw_ofs;
    assign o_rec.pw_rate        = r_rec.pw_rate;
    assign o_rec.dts_next_au    = r_rec.dts_next_au;
    assign o_rec.malformed      = r_rec.malformed;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || o_rec.ready))
        else $error("pending record overwritten");

endmodule

>>> src/ts_adaptation_field_parser_core.sv
// ----------------------------------------------------------------------------
// ts_adaptation_field_parser_core
// Byte-serial MPEG-2 transport stream adaptation field parser.
//
//   channel  dir  transaction
//   i_byte   in   one field byte, first marks the length byte
//   o_rec    out  one parsed record per completed field, on its last byte
//
// one byte is accepted every cycle, but a field's last byte waits while the result
// register still holds a pending record; a record passes the input register, then
// the result register, after the transaction of the field's last byte; the per-byte
// state machine keeps the rate of one byte per cycle for every field layout
// reset clears the parser to idle and empties both register stages
// a stalled record holds in the result register; bytes keep flowing until a
// further field ends while that record is still pending
// ----------------------------------------------------------------------------
module ts_adaptation_field_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsaf_byte_if.sink   i_byte,
    tsaf_rec_if.source  o_rec
);

    tsaf_pkg::t_stage  stage;
    tsaf_pkg::t_record rec;
    logic              fire;
    logic              emit;
    logic              out_free;

    tsaf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_adv   (fire),
        .o_stage (stage)
    );

    tsaf_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (stage),
        .i_out_free (out_free),
        .o_fire     (fire),
        .o_emit     (emit),
        .o_rec      (rec)
    );

    tsaf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && emit),
        .i_rec   (rec),
        .o_free  (out_free),
        .o_rec   (o_rec)
    );

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the transport stream adaptation field parser core. Fields
// built byte by byte (well-formed, truncated, wrong extension length,
// restarted, stray bytes, zero length) go in with random gaps. An in-bench
// parser predicts one record per completed field. Records leave under random
// back-pressure and are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] b;
        logic       first;
    } t_field_byte;

    logic clk;
    logic rst_n;

    tsaf_byte_if byte_ch ();
    tsaf_rec_if  rec_ch ();

    ts_adaptation_field_parser_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch),
        .o_rec   (rec_ch)
    );

    t_field_byte       byte_q[$];
    tsaf_pkg::t_record pending_records[$];
    int                byte_xfer_cnt = 0;
    int                stim_cnt = 0;
    int                mismatches = 0;
    logic              quiet;

    // in-bench parser state
    logic [7:0]       fld_len = '0;
    logic [7:0]       byte_cnt = '0;
    tsaf_pkg::t_phase phase = tsaf_pkg::PH_IDLE;
    logic [2:0]       pidx = '0;
    logic [7:0]       skip_rem = '0;
    logic [7:0]       ext_rem = '0;
    logic [47:0]      gather = '0;
    logic [7:0]       hdr_flags = '0;
    logic [7:0]       splice_val = '0;
    logic [7:0]       priv_len = '0;
    logic             overrun = 1'b0;
    logic [32:0]      dts = '0;
    logic [32:0]      pcr_b = '0;
    logic [8:0]       pcr_e = '0;
    logic [32:0]      opcr_b = '0;
    logic [8:0]       opcr_e = '0;
    logic [2:0]       ext_flags = '0;
    logic             ltw_v = 1'b0;
    logic [3:0]       splice_kind = '0;
    logic [14:0]      ltw = '0;
    logic [21:0]      rate = '0;

    assign quiet = (byte_xfer_cnt >= 300) && (byte_xfer_cnt < 650);

    function automatic void clear_parse();
        fld_len = '0; byte_cnt = '0; phase = tsaf_pkg::PH_IDLE; pidx = '0;
        skip_rem = '0; ext_rem = '0; gather = '0;
        hdr_flags = '0; splice_val = '0; priv_len = '0; overrun = 1'b0; dts = '0;
        pcr_b = '0; pcr_e = '0; opcr_b = '0; opcr_e = '0;
        ext_flags = '0; ltw_v = 1'b0; splice_kind = '0; ltw = '0; rate = '0;
    endfunction

    function automatic logic content_due(tsaf_pkg::t_phase p);
        case (p)
            tsaf_pkg::PH_PCR:      return hdr_flags[4];
            tsaf_pkg::PH_OPCR:     return hdr_flags[3];
            tsaf_pkg::PH_SPLICE:   return hdr_flags[2];
            tsaf_pkg::PH_PRIVLEN:  return hdr_flags[1];
            tsaf_pkg::PH_PRIVSKIP: return skip_rem != 0;
            tsaf_pkg::PH_EXTLEN:   return hdr_flags[0];
            tsaf_pkg::PH_EXTFLAGS: return ext_rem != 0;
            tsaf_pkg::PH_LTW:      return ext_flags[0];
            tsaf_pkg::PH_PIECE:    return ext_flags[1];
            tsaf_pkg::PH_SEAM:     return ext_flags[2];
            tsaf_pkg::PH_EXTSKIP:  return ext_rem != 0;
            default:               return 1'b1;
        endcase
    endfunction

    function automatic void step_past(tsaf_pkg::t_phase p);
        int k;
        k = int'(p) + 1;
        while (k < int'(tsaf_pkg::PH_STUFF) && !content_due(tsaf_pkg::t_phase'(k[3:0])))
            k++;
        phase  = tsaf_pkg::t_phase'(k[3:0]);
        pidx   = '0;
        gather = '0;
    endfunction

    function automatic void count_ext_byte();
        if (ext_rem == 0) begin
            overrun = 1'b1;
        end else begin
            ext_rem--;
        end
    endfunction

    function automatic void gather_byte(logic [7:0] b, int len);
        gather = {gather[39:0], b};
        pidx++;
        if (int'(pidx) < len)
            return;
        case (phase)
            tsaf_pkg::PH_PCR: begin
                pcr_b = gather[47:15];
                pcr_e = gather[8:0];
            end
            tsaf_pkg::PH_OPCR: begin
                opcr_b = gather[47:15];
                opcr_e = gather[8:0];
            end
            tsaf_pkg::PH_LTW: begin
                ltw_v = gather[15];
                ltw   = gather[14:0];
            end
            tsaf_pkg::PH_PIECE: rate = gather[21:0];
            default: begin
                splice_kind = gather[39:36];
                dts = {gather[35:33], gather[31:17], gather[15:1]};
            end
        endcase
        step_past(phase);
    endfunction

    function automatic tsaf_pkg::t_record make_record(logic malf);
        tsaf_pkg::t_record r;
        r.header_flags   = hdr_flags;
        r.pcr_base       = pcr_b;
        r.pcr_extension  = pcr_e;
        r.opcr_base      = opcr_b;
        r.opcr_extension = opcr_e;
        r.splice_cntdn   = splice_val;
        r.private_length = priv_len;
        r.extension_info = {splice_kind, ltw_v, ext_flags};
        r.ltw_ofs        = ltw;
        r.pw_rate        = rate;
        r.dts_next_au    = dts;
        r.malformed      = malf;
        return r;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic first);
        if (first) begin
            clear_parse();
            fld_len = b;
            if (b == 0) begin
                pending_records.push_back(make_record(1'b0));
            end else begin
                phase = tsaf_pkg::PH_FLAGS;
            end
            return;
        end
        if (phase == tsaf_pkg::PH_IDLE)
            return;
        byte_cnt++;
        case (phase)
            tsaf_pkg::PH_FLAGS: begin
                hdr_flags = b;
                step_past(tsaf_pkg::PH_FLAGS);
            end
            tsaf_pkg::PH_PCR, tsaf_pkg::PH_OPCR: gather_byte(b, 6);
            tsaf_pkg::PH_SPLICE: begin
                splice_val = b;
                step_past(tsaf_pkg::PH_SPLICE);
            end
            tsaf_pkg::PH_PRIVLEN: begin
                priv_len = b;
                skip_rem = b;
                step_past(tsaf_pkg::PH_PRIVLEN);
            end
            tsaf_pkg::PH_PRIVSKIP: begin
                if (skip_rem != 0)
                    skip_rem--;
                if (skip_rem == 0)
                    step_past(tsaf_pkg::PH_PRIVSKIP);
            end
            tsaf_pkg::PH_EXTLEN: begin
                ext_rem = b;
                step_past(tsaf_pkg::PH_EXTLEN);
            end
            tsaf_pkg::PH_EXTFLAGS: begin
                count_ext_byte();
                ext_flags = {b[5], b[6], b[7]};
                step_past(tsaf_pkg::PH_EXTFLAGS);
            end
            tsaf_pkg::PH_LTW: begin
                count_ext_byte();
                gather_byte(b, 2);
            end
            tsaf_pkg::PH_PIECE: begin
                count_ext_byte();
                gather_byte(b, 3);
            end
            tsaf_pkg::PH_SEAM: begin
                count_ext_byte();
                gather_byte(b, 5);
            end
            tsaf_pkg::PH_EXTSKIP: begin
                if (ext_rem != 0)
                    ext_rem--;
                if (ext_rem == 0)
                    step_past(tsaf_pkg::PH_EXTSKIP);
            end
            default: ;
        endcase
        if (byte_cnt != fld_len)
            return;
        pending_records.push_back(make_record(overrun || (phase != tsaf_pkg::PH_STUFF)));
        phase = tsaf_pkg::PH_IDLE;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
    endfunction

    task automatic push_byte(logic [7:0] b, logic first);
        byte_q.push_back('{b, first});
        stim_cnt++;
    endtask

    // mode 0 well-formed, 1 cut short, 2 extension length off, 3 restarted
    task automatic add_field(int mode);
        logic [7:0] body[$];
        logic [7:0] ext[$];
        logic [7:0] hdr;
        logic [7:0] ef;
        int plen;
        int elen;
        int flen;
        int cut;
        hdr = 8'($urandom);
        body.push_back(hdr);
        if (hdr[4])
            repeat (6) body.push_back(8'($urandom));
        if (hdr[3])
            repeat (6) body.push_back(8'($urandom));
        if (hdr[2])
            body.push_back(8'($urandom));
        if (hdr[1]) begin
            plen = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
            body.push_back(8'(plen));
            repeat (plen) body.push_back(8'($urandom));
        end
        if (hdr[0]) begin
            ef = 8'($urandom);
            ext.push_back(ef);
            if (ef[7])
                repeat (2) ext.push_back(8'($urandom));
            if (ef[6])
                repeat (3) ext.push_back(8'($urandom));
            if (ef[5])
                repeat (5) ext.push_back(8'($urandom));
            repeat ($urandom_range(0, 2)) ext.push_back(8'($urandom));
            elen = ext.size();
            if (mode == 2)
                elen = $urandom_range(0, ext.size() + 3);
            body.push_back(8'(elen));
            foreach (ext[k])
                body.push_back(ext[k]);
            for (int k = ext.size(); k < elen; k++)
                body.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 3)) body.push_back(8'hFF);
        flen = (body.size() > 255) ? 255 : body.size();
        if (mode == 1 && flen > 1)
            flen = $urandom_range(1, flen - 1);
        cut = flen;
        if (mode == 3)
            cut = $urandom_range(0, flen - 1);
        push_byte(8'(flen), 1'b1);
        for (int k = 0; k < cut; k++)
            push_byte(body[k], 1'b0);
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("** ts_adaptation_field_parser_core: FAILED **");
        $finish;
    end

    // byte driver
    always @(posedge clk) begin
        t_field_byte nxt;
        if (!rst_n) begin
            byte_ch.valid <= 1'b0;
        end else if (!byte_ch.valid || byte_ch.ready) begin
            if (byte_q.size() == 0 || (!quiet && $urandom_range(0, 99) < 34)) begin
                byte_ch.valid <= 1'b0;
            end else begin
                nxt = byte_q.pop_front();
                byte_ch.valid      <= 1'b1;
                byte_ch.field_byte <= nxt.b;
                byte_ch.first      <= nxt.first;
            end
        end
    end

    // byte monitor feeding the prediction
    always @(posedge clk) begin
        if (rst_n && byte_ch.valid && byte_ch.ready) begin
            parse_byte(byte_ch.field_byte, byte_ch.first);
            byte_xfer_cnt++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            rec_ch.ready <= 1'b0;
        end else begin
            rec_ch.ready <= quiet || ($urandom_range(0, 99) >= 34);
        end
    end

    // record monitor
    always @(posedge clk) begin
        tsaf_pkg::t_record want;
        if (rst_n && rec_ch.valid && rec_ch.ready) begin
            if (pending_records.size() == 0) begin
                note_mismatch($sformatf("record with none expected, header_flags %0h",
                                        rec_ch.header_flags));
            end else begin
                want = pending_records.pop_front();
                check_field("header_flags", 64'(want.header_flags), 64'(rec_ch.header_flags));
                check_field("pcr_base", 64'(want.pcr_base), 64'(rec_ch.pcr_base));
                check_field("pcr_extension", 64'(want.pcr_extension),
                            64'(rec_ch.pcr_extension));
                check_field("opcr_base", 64'(want.opcr_base), 64'(rec_ch.opcr_base));
                check_field("opcr_extension", 64'(want.opcr_extension),
                            64'(rec_ch.opcr_extension));
                check_field("splice_cntdn", {56'd0, want.splice_cntdn},
                            {56'd0, rec_ch.splice_cntdn});
                check_field("private_length", 64'(want.private_length),
                            64'(rec_ch.private_length));
                check_field("extension_info", 64'(want.extension_info),
                            64'(rec_ch.extension_info));
                check_field("ltw_ofs", 64'(want.ltw_ofs), 64'(rec_ch.ltw_ofs));
                check_field("pw_rate", 64'(want.pw_rate), 64'(rec_ch.pw_rate));
                check_field("dts_next_au", 64'(want.dts_next_au), 64'(rec_ch.dts_next_au));
                check_field("malformed", 64'(want.malformed), 64'(rec_ch.malformed));
            end
        end
    end

    initial begin
        int pick;
        rst_n              = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.field_byte = '0;
        byte_ch.first      = 1'b0;
        rec_ch.ready       = 1'b0;

        // zero length field
        push_byte(8'd0, 1'b1);
        // every flag set but only the flags byte fits
        push_byte(8'd1, 1'b1);
        push_byte(8'hFF, 1'b0);
        // pcr all ones and most negative splice countdown
        push_byte(8'd8, 1'b1);
        push_byte(8'h14, 1'b0);
        repeat (6) push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        // stray byte with no field open
        push_byte(8'hA5, 1'b0);
        // restart in the middle of a field
        push_byte(8'd3, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'd1, 1'b1);
        push_byte(8'h00, 1'b0);
        // extension length zero, then stuffing
        push_byte(8'd3, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);

        while (stim_cnt < 1100) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                add_field(0);
            else if (pick < 80)
                add_field(1);
            else if (pick < 88)
                add_field(2);
            else if (pick < 93)
                add_field(3);
            else if (pick < 97)
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
            else
                push_byte(8'd0, 1'b1);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk); while (byte_q.size() != 0 || byte_ch.valid);
        while (pending_records.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0) begin
            $display("** ts_adaptation_field_parser_core: PASSED **");
        end else begin
            $display("** ts_adaptation_field_parser_core: FAILED **");
        end
        $finish;
    end

endmodule
